>>> design/neighbour_liveness_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neighbour liveness table
// Concurrent checks that disappear when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_LIVENESS_TABLE_ASSERT_SVH
`define NEIGHBOUR_LIVENESS_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define NLT_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("nlt assertion failed");
`define NLT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("nlt assertion failed");
`else
`define NLT_ASSERT_IMPL(lbl, pre, post)
`define NLT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> design/nlt_pkg.sv
// ----------------------------------------------------------------------------
// Neighbour liveness table package
// Shared widths, codes and structs.
// ----------------------------------------------------------------------------
package nlt_pkg;
  localparam int NODE_W      = 64;
  localparam int TIME_W      = 32;
  localparam int LIFE_W      = 16;
  localparam int MAX_RESULTS = 16;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_REMOVE  = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  localparam logic [1:0] STATUS_NONE         = 2'd0;
  localparam logic [1:0] STATUS_RECONNECTED  = 2'd1;
  localparam logic [1:0] STATUS_DISCONNECTED = 2'd2;

  localparam logic OP_HELLO = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic REG_LIFETIME = 1'b0;
  localparam logic REG_BIDIR    = 1'b1;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_HFIN, ST_FLUSH} nlt_state_e;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] stamp;
  } nlt_view_t;

  typedef struct packed {
    logic              adv;
    logic              clr;
    logic              stamp_wr;
    logic              ins;
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] now;
  } nlt_cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] node;
    logic              bidir;
    logic [1:0]        status;
    logic              last;
  } nlt_result_t;
endpackage

>>> design/nlt_if.sv
// ----------------------------------------------------------------------------
// Neighbour liveness table channels
// Valid/ready interfaces for hello/tick items and notices.
// ----------------------------------------------------------------------------
interface nlt_in_if;
  import nlt_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [NODE_W-1:0] node_id;
  logic [TIME_W-1:0] now_seconds;
  modport source (output valid, op, node_id, now_seconds, input ready);
  modport sink   (input valid, op, node_id, now_seconds, output ready);
endinterface

interface nlt_out_if;
  import nlt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        notice_kind;
  logic [NODE_W-1:0] notice_node;
  logic              notice_bidirectional;
  logic [1:0]        status_change;
  logic              last;
  modport source (output valid, notice_kind, notice_node, notice_bidirectional,
                  status_change, last, input ready);
  modport sink   (input valid, notice_kind, notice_node, notice_bidirectional,
                  status_change, last, output ready);
endinterface

>>> design/nlt_cell.sv
// ----------------------------------------------------------------------------
// Neighbour table cell
// Holds one entry and passes the walk token to the next cell.
// ----------------------------------------------------------------------------
module nlt_cell #(
  parameter int IdW  = 64,
  parameter int PosW = 4,
  parameter int Idx  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              active_i,
  output logic              active_o,
  input  nlt_pkg::nlt_cmd_t cmd_i,
  input  logic [PosW-1:0]   ins_idx_i,
  output nlt_pkg::nlt_view_t view_o,
  output logic              valid_o
);
  import nlt_pkg::*;

  logic              active_q;
  logic              valid_q;
  logic [IdW-1:0]    node_q;
  logic [TIME_W-1:0] stamp_q;
  logic              sel_ins;

  assign sel_ins = cmd_i.ins && (ins_idx_i == PosW'(Idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (cmd_i.adv) active_q <= active_i;
      if (sel_ins) begin
        valid_q <= 1'b1;
      end else if (cmd_i.clr && active_q) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_ins) begin
      node_q  <= cmd_i.node[IdW-1:0];
      stamp_q <= cmd_i.now;
    end else if (cmd_i.stamp_wr && active_q) begin
      stamp_q <= cmd_i.now;
    end
  end

  assign active_o = active_q;
  assign valid_o  = valid_q;

  always_comb begin
    view_o = '0;
    if (active_q) begin
      view_o.valid = valid_q;
      view_o.node  = NODE_W'(node_q);
      view_o.stamp = stamp_q;
    end
  end
endmodule

>>> design/neighbour_liveness_table.sv
// ----------------------------------------------------------------------------
// Neighbour liveness table
// An item walks a token along TABLE_DEPTH cells, one cell per cycle unless a
// tick result must wait for a full output; ready is high only when idle.
// Tick notices can appear during the walk, the final one after the walk.
// Reset clears all valid bits, marks the node connected, and sets
// lifetime to 3 seconds and bidirectional to 1.
// ----------------------------------------------------------------------------
`include "neighbour_liveness_table_assert.svh"
module neighbour_liveness_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_BYTES    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nlt_in_if.sink      in_i,
  nlt_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nlt_pkg::*;

  localparam int IdW  = ID_BYTES * 8;
  localparam int PosW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int EmW  = $clog2(MAX_RESULTS + 1);

  nlt_state_e        state_q, state_d;
  logic [PosW-1:0]   pos_q, pos_d, free_idx_q, free_idx_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [EmW-1:0]    emit_q, emit_d;
  logic              conn_q, conn_d, op_q, op_d, recon_q, recon_d;
  logic              hit_q, hit_d, free_v_q, free_v_d;
  logic              pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic [NODE_W-1:0] id_q, id_d;
  logic [TIME_W-1:0] now_q, now_d;
  nlt_result_t       pend_q, pend_d, out_q, out_d;
  logic [LIFE_W-1:0] life_q;
  logic              bidir_q;

  nlt_cmd_t           cmd;
  nlt_view_t          views [TABLE_DEPTH];
  nlt_view_t          view;
  logic [TABLE_DEPTH-1:0] act_vec, valid_vec;
  logic               start, out_free, load_out, new_res;
  logic [32:0]        age;
  logic [17:0]        three_life;
  logic               fail_c, erase_c, match_c;
  logic [1:0]         st_rm;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BIDIR) ? {31'b0, bidir_q} : {16'b0, life_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q  <= LIFE_W'(3);
      bidir_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_LIFETIME) begin
        life_q <= pwdata[LIFE_W-1:0];
      end else begin
        bidir_q <= pwdata[0];
      end
    end
  end

  // cell row
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic act_in;
    if (g == 0) begin : g_head
      assign act_in = start;
    end else begin : g_link
      assign act_in = act_vec[g-1];
    end
    nlt_cell #(.IdW(IdW), .PosW(PosW), .Idx(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (act_in),
      .active_o (act_vec[g]),
      .cmd_i    (cmd),
      .ins_idx_i(free_idx_q),
      .view_o   (views[g]),
      .valid_o  (valid_vec[g])
    );
  end

  always_comb begin
    view = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) view = view | views[i];
  end

  assign age        = {1'b0, now_q} - {1'b0, view.stamp};
  assign three_life = {1'b0, life_q, 1'b0} + 18'(life_q);
  assign fail_c     = view.valid && !age[32] && (age[31:0] > 32'(life_q));
  assign erase_c    = {age[31:0], 1'b0} > 33'(three_life);
  assign match_c    = view.valid && (view.node == id_q);
  assign out_free   = !out_v_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    free_idx_d = free_idx_q;
    cnt_d      = cnt_q;
    emit_d     = emit_q;
    conn_d     = conn_q;
    op_d       = op_q;
    recon_d    = recon_q;
    hit_d      = hit_q;
    free_v_d   = free_v_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    id_d       = id_q;
    now_d      = now_q;
    out_d      = out_q;
    load_out   = 1'b0;
    start      = 1'b0;
    new_res    = 1'b0;
    st_rm      = STATUS_NONE;
    cmd          = '0;
    cmd.adv      = 1'b1;
    cmd.node     = id_q;
    cmd.now      = now_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          op_d     = in_i.op;
          id_d     = NODE_W'(in_i.node_id[IdW-1:0]);
          now_d    = in_i.now_seconds;
          hit_d    = 1'b0;
          free_v_d = 1'b0;
          emit_d   = '0;
          pos_d    = '0;
          if (in_i.op == OP_HELLO) begin
            recon_d = (cnt_q == '0) || !conn_q;
            conn_d  = 1'b1;
            start   = 1'b1;
            state_d = ST_WALK;
          end else if (conn_q) begin
            start   = 1'b1;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (op_q == OP_HELLO) begin
          if (match_c && !hit_q) begin
            hit_d        = 1'b1;
            cmd.stamp_wr = 1'b1;
          end
          if (!view.valid && !free_v_q) begin
            free_v_d   = 1'b1;
            free_idx_d = pos_q;
          end
        end else begin
          new_res = fail_c && (emit_q < EmW'(MAX_RESULTS));
          if (new_res && pend_v_q && !out_free) begin
            cmd.adv = 1'b0;  // hold the token until the output drains
          end else if (fail_c) begin
            if ((cnt_q == CntW'(1)) && conn_q) begin
              conn_d = 1'b0;
              st_rm  = STATUS_DISCONNECTED;
            end
            if (erase_c) begin
              cmd.clr = 1'b1;
              cnt_d   = cnt_q - CntW'(1);
            end
            if (new_res) begin
              emit_d = emit_q + EmW'(1);
              if (pend_v_q) begin
                load_out = 1'b1;
                out_d    = pend_q;
              end
              pend_v_d = 1'b1;
              pend_d   = '{kind: KIND_REMOVE, node: view.node, bidir: bidir_q,
                           status: st_rm, last: 1'b0};
            end
          end
        end
        if (cmd.adv) begin
          pos_d = pos_q + PosW'(1);
          if (pos_q == PosW'(TABLE_DEPTH - 1)) begin
            state_d = (op_q == OP_HELLO) ? ST_HFIN : ST_FLUSH;
          end
        end
      end
      ST_HFIN: begin
        out_d = '{kind: KIND_STATUS, node: id_q, bidir: bidir_q,
                  status: recon_q ? STATUS_RECONNECTED : STATUS_NONE, last: 1'b1};
        if (hit_q) begin
          if (!recon_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          if (free_v_q) begin
            cmd.ins    = 1'b1;
            cnt_d      = cnt_q + CntW'(1);
            out_d.kind = KIND_ADD;
          end else begin
            out_d.kind = KIND_DROPPED;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          load_out   = 1'b1;
          out_d      = pend_q;
          out_d.last = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_v_d = load_out ? 1'b1 : (out_o.ready ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      free_idx_q <= '0;
      cnt_q    <= '0;
      emit_q   <= '0;
      conn_q   <= 1'b1;
      op_q     <= OP_HELLO;
      recon_q  <= 1'b0;
      hit_q    <= 1'b0;
      free_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      free_idx_q <= free_idx_d;
      cnt_q    <= cnt_d;
      emit_q   <= emit_d;
      conn_q   <= conn_d;
      op_q     <= op_d;
      recon_q  <= recon_d;
      hit_q    <= hit_d;
      free_v_q <= free_v_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    now_q  <= now_d;
    pend_q <= pend_d;
    if (load_out) out_q <= out_d;
  end

  assign out_o.valid                = out_v_q;
  assign out_o.notice_kind          = out_q.kind;
  assign out_o.notice_node          = out_q.node;
  assign out_o.notice_bidirectional = out_q.bidir;
  assign out_o.status_change        = out_q.status;
  assign out_o.last                 = out_q.last;

  `NLT_ASSERT_IMPL(a_token_onehot, 1'b1, $onehot0(act_vec))
  `NLT_ASSERT_IMPL(a_count_tracks, 1'b1, $countones(valid_vec) == int'(cnt_q))
  `NLT_ASSERT_IMPL(a_idle_drained, state_q == ST_IDLE, !pend_v_q)
  `NLT_ASSERT_NEXT(a_tick_offline, state_q == ST_IDLE && in_i.valid && in_i.op == OP_TICK && !conn_q, state_q == ST_IDLE)
endmodule

>>> tb/sv/tb_neighbour_liveness_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Neighbour liveness table testbench
// Drives hello and tick transactions over the valid/ready channels, programs
// lifetime and link direction over APB while the table is idle, predicts the
// notices from its own copy of the table and checks each one in order.
// ----------------------------------------------------------------------------
module tb_neighbour_liveness_table;
  import nlt_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [NODE_W-1:0] ID_MASK = {NODE_W{1'b1}};
  localparam logic [2:0] ADDR_LIFETIME = {REG_LIFETIME, 2'b00};
  localparam logic [2:0] ADDR_BIDIR    = {REG_BIDIR, 2'b00};
  localparam int SETTLE_CYCLES = DEPTH + 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int POOL_SIZE     = 20;

  typedef struct {
    logic              op;
    logic [NODE_W-1:0] id;
    logic [TIME_W-1:0] now;
    bit                typed;
    nlt_result_t       res;
  } hello_row_t;

  logic clk_i;
  logic rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  nlt_in_if  in_ch ();
  nlt_out_if out_ch ();

  neighbour_liveness_table dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // table copy
  logic [NODE_W-1:0] tbl_node  [DEPTH];
  logic [TIME_W-1:0] tbl_stamp [DEPTH];
  bit                tbl_live  [DEPTH];
  bit                connected;
  logic [LIFE_W-1:0] lifetime;
  bit                bidir;

  nlt_result_t notices_due[$];
  int          fails;
  int          items_sent;
  int          notices_seen;
  int          tx_idle_pct;
  int          rx_stall_pct;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) if (tbl_live[i]) n++;
    return n;
  endfunction

  function automatic void push_notice(ref int unsigned cnt,
                                      input logic [1:0] kind,
                                      input logic [NODE_W-1:0] node,
                                      input logic [1:0] status);
    nlt_result_t r;
    if (cnt >= MAX_RESULTS) return;
    r.kind   = kind;
    r.node   = node & ID_MASK;
    r.bidir  = bidir;
    r.status = status;
    r.last   = 1'b0;
    notices_due.push_back(r);
    cnt++;
  endfunction

  // Update the table copy and queue the notices the transaction causes.
  function automatic int unsigned predict_notices(logic op, logic [NODE_W-1:0] raw_id,
                                                  logic [TIME_W-1:0] now);
    logic [NODE_W-1:0] id;
    logic [1:0] status;
    int hit, free_slot;
    int unsigned cnt;
    longint age, life;
    id = raw_id & ID_MASK;
    cnt = 0;
    if (op == OP_HELLO) begin
      status = (live_count() == 0 || !connected) ? STATUS_RECONNECTED : STATUS_NONE;
      connected = 1'b1;
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_live[i]) begin
          if (hit < 0 && tbl_node[i] == id) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        tbl_stamp[hit] = now;
        if (status != STATUS_NONE) push_notice(cnt, KIND_STATUS, id, status);
      end else if (free_slot >= 0) begin
        tbl_live[free_slot]  = 1'b1;
        tbl_node[free_slot]  = id;
        tbl_stamp[free_slot] = now;
        push_notice(cnt, KIND_ADD, id, status);
      end else begin
        push_notice(cnt, KIND_DROPPED, id, status);
      end
    end else if (connected) begin
      life = longint'(lifetime);
      for (int i = 0; i < DEPTH; i++) begin
        if (!tbl_live[i]) continue;
        age = longint'(now) - longint'(tbl_stamp[i]);
        if (age <= life) continue;
        status = STATUS_NONE;
        if (live_count() == 1) begin
          if (connected) status = STATUS_DISCONNECTED;
          connected = 1'b0;
        end
        push_notice(cnt, KIND_REMOVE, tbl_node[i], status);
        if (2 * age > 3 * life) tbl_live[i] = 1'b0;
      end
    end
    if (cnt > 0) notices_due[notices_due.size() - 1].last = 1'b1;
    return cnt;
  endfunction

  task automatic send_item(logic op, logic [NODE_W-1:0] id, logic [TIME_W-1:0] now);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.node_id     <= id;
    in_ch.now_seconds <= now;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_predicted(logic op, logic [NODE_W-1:0] id, logic [TIME_W-1:0] now);
    send_item(op, id, now);
    void'(predict_notices(op, id, now));
  endtask

  task automatic run_rows(hello_row_t rows[]);
    int unsigned n;
    foreach (rows[i]) begin
      send_item(rows[i].op, rows[i].id, rows[i].now);
      if (rows[i].typed) begin
        n = predict_notices(rows[i].op, rows[i].id, rows[i].now);
        // replace the predicted notice by the hand-written one
        if (n != 1) begin
          $error("row %0d: predictor gave %0d notices, table says 1", i, n);
          fails++;
        end
        repeat (n) void'(notices_due.pop_back());
        notices_due.push_back(rows[i].res);
      end else begin
        void'(predict_notices(rows[i].op, rows[i].id, rows[i].now));
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (notices_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_cycle(logic wr, logic [2:0] addr, logic [31:0] data,
                           output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_table(logic [LIFE_W-1:0] life, bit bd);
    logic [31:0] rd;
    apb_cycle(1'b1, ADDR_LIFETIME, {16'hFFFF, life}, rd);
    apb_cycle(1'b1, ADDR_BIDIR, {31'h7FFF_FFFE, bd}, rd);
    lifetime = life;
    bidir    = bd;
    apb_cycle(1'b0, ADDR_LIFETIME, '0, rd);
    if (rd[LIFE_W-1:0] !== life) begin
      $error("lifetime readback: expected %0d actual %0d", life, rd[LIFE_W-1:0]);
      fails++;
    end
    apb_cycle(1'b0, ADDR_BIDIR, '0, rd);
    if (rd[0] !== bd) begin
      $error("bidirectional readback: expected %0d actual %0d", bd, rd[0]);
      fails++;
    end
    @(posedge clk_i);
  endtask

  // Random traffic: a pool of neighbours larger than the table, time mostly
  // advancing around the lifetime so entries age, fail and get erased.
  task automatic random_phase(int count, int hold_at);
    logic [NODE_W-1:0] pool [POOL_SIZE];
    logic [TIME_W-1:0] now;
    int unsigned step;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = {$urandom, $urandom};
    now = $urandom_range(1000);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      if ($urandom_range(99) < 5) begin
        now = $urandom;
      end else begin
        step = (lifetime > 1000) ? $urandom_range(140000) : $urandom_range(2 * lifetime + 2);
        now = now + step;
      end
      if ($urandom_range(99) < 30)
        send_predicted(OP_TICK, {$urandom, $urandom}, now);
      else
        send_predicted(OP_HELLO, pool[$urandom_range(POOL_SIZE - 1)], now);
    end
  endtask

  // Receiver: check each notice and decide ready for the next cycle.
  initial begin
    int hold_cnt;
    nlt_result_t want;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        notices_seen++;
        if (notices_due.size() == 0) begin
          $error("unexpected notice kind %0d node %h", out_ch.notice_kind, out_ch.notice_node);
          fails++;
        end else begin
          want = notices_due.pop_front();
          if (out_ch.notice_kind !== want.kind) begin
            $error("notice_kind: expected %0d actual %0d", want.kind, out_ch.notice_kind);
            fails++;
          end
          if (out_ch.notice_node !== want.node) begin
            $error("notice_node: expected %h actual %h", want.node, out_ch.notice_node);
            fails++;
          end
          if (out_ch.notice_bidirectional !== want.bidir) begin
            $error("notice_bidirectional: expected %0d actual %0d", want.bidir,
                   out_ch.notice_bidirectional);
            fails++;
          end
          if (out_ch.status_change !== want.status) begin
            $error("status_change: expected %0d actual %0d", want.status, out_ch.status_change);
            fails++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, out_ch.last);
            fails++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    hello_row_t opening[];
    hello_row_t closing[];
    fails = 0;
    items_sent = 0;
    notices_seen = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_HELLO;
    in_ch.node_id     <= '0;
    in_ch.now_seconds <= '0;
    out_ch.ready      <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    for (int i = 0; i < DEPTH; i++) tbl_live[i] = 1'b0;
    connected = 1'b1;
    lifetime  = 3;
    bidir     = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: first neighbour reconnects, known one is silent, aging
    opening = '{
      '{OP_HELLO, 64'hA5, 32'd1, 1'b1, '{KIND_ADD, 64'hA5, 1'b1, STATUS_RECONNECTED, 1'b1}},
      '{OP_HELLO, 64'hA5, 32'd1, 1'b0, '{default: '0}},
      '{OP_HELLO, '1, 32'hFFFF_FFFF, 1'b1, '{KIND_ADD, '1, 1'b1, STATUS_NONE, 1'b1}},
      '{OP_TICK, '0, 32'd5, 1'b0, '{default: '0}},
      '{OP_TICK, '0, 32'd6, 1'b0, '{default: '0}}
    };
    run_rows(opening);
    // fill the table
    for (int i = 0; i < DEPTH - 1; i++) send_predicted(OP_HELLO, 64'h100 + i, 32'd10);
    // full table, mass expiry, sole entry disconnect, repair by hello
    closing = '{
      '{OP_HELLO, 64'h0, 32'd10, 1'b1, '{KIND_DROPPED, 64'h0, 1'b1, STATUS_NONE, 1'b1}},
      '{OP_TICK, '0, 32'd100, 1'b0, '{default: '0}},
      '{OP_HELLO, '1, 32'd100, 1'b0, '{default: '0}},
      '{OP_TICK, '0, 32'd104, 1'b1, '{KIND_REMOVE, '1, 1'b1, STATUS_DISCONNECTED, 1'b1}},
      '{OP_TICK, '0, 32'd200, 1'b0, '{default: '0}},
      '{OP_HELLO, '1, 32'd201, 1'b1, '{KIND_STATUS, '1, 1'b1, STATUS_RECONNECTED, 1'b1}},
      '{OP_TICK, '0, 32'd300, 1'b0, '{default: '0}},
      '{OP_HELLO, 64'h5, 32'd301, 1'b1, '{KIND_ADD, 64'h5, 1'b1, STATUS_RECONNECTED, 1'b1}}
    };
    run_rows(closing);

    wait_idle();
    program_table(16'd0, 1'b0);
    random_phase(38, 10);

    wait_idle();
    tx_idle_pct = 77;
    program_table(16'd2, 1'b1);
    random_phase(38, -1);

    wait_idle();
    tx_idle_pct = 0;
    rx_stall_pct = 77;
    program_table(16'hFFFF, 1'b0);
    random_phase(38, -1);

    wait_idle();
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    program_table(16'd7, 1'b1);
    random_phase(38, -1);

    wait_idle();
    $display("Covered %0d hello/tick transactions and %0d notices", items_sent, notices_seen);
    $display("over lifetimes 0, 2, 3, 7 and 65535, both link flags and four idle mixes");
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
